@@ rtl/dtoi_pkg.sv @@
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and constants of the decimal text to int64 parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtoi_pkg;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusRange   = 2'd2;

  // largest magnitude that can still be scaled by ten
  localparam logic signed [63:0] AccMaxDiv = 64'sd922337203685477580;
  localparam logic signed [63:0] AccMinDiv = -64'sd922337203685477580;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIGIT,
    KIND_MINUS,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/dtoi_front.sv @@
// ----------------------------------------------------------------------------
// dtoi_front
// Accepts text bytes and classifies each one for the accumulate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      character,
  input  wire logic            no_character,
  input  wire logic            last_char,
  input  wire logic            char_valid,
  output logic                 char_stall,
  input  wire logic            queue_full,
  output logic                 push,
  output dtoi_pkg::entry_t     push_entry
);

  logic at_start;

  assign char_stall = queue_full;
  assign push       = char_valid && !queue_full;

  always_comb begin
    push_entry.last  = last_char;
    push_entry.digit = 4'(character - dtoi_pkg::CharZero);
    if (no_character) begin
      push_entry.kind = dtoi_pkg::KIND_NONE;
    end else if (character >= dtoi_pkg::CharZero && character <= dtoi_pkg::CharNine) begin
      push_entry.kind = dtoi_pkg::KIND_DIGIT;
    end else if (at_start && character == dtoi_pkg::CharMinus) begin
      push_entry.kind = dtoi_pkg::KIND_MINUS;
    end else begin
      push_entry.kind = dtoi_pkg::KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (push) begin
      if (last_char) begin
        at_start <= 1'b1;
      end else if (!no_character) begin
        at_start <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtoi_queue.sv @@
// ----------------------------------------------------------------------------
// dtoi_queue
// Short request queue between the classify and accumulate stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire dtoi_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  nonempty,
  output dtoi_pkg::entry_t      head
);

  dtoi_pkg::entry_t                   slots [dtoi_pkg::QueueDepth];
  logic [dtoi_pkg::QueuePtrW-1:0]     wr_ptr;
  logic [dtoi_pkg::QueuePtrW-1:0]     rd_ptr;
  logic [dtoi_pkg::QueueCntW-1:0]     count;

  assign full     = count == dtoi_pkg::QueueCntW'(dtoi_pkg::QueueDepth);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtoi_back.sv @@
// ----------------------------------------------------------------------------
// dtoi_back
// Accumulates digits with range checks and registers the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_nonempty,
  input  wire dtoi_pkg::entry_t   q_head,
  output logic                    pop,
  output logic signed [63:0]      value,
  output logic [1:0]              status,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  logic signed [63:0] acc;
  logic               negative;
  logic               digit_seen;
  logic [1:0]         err;

  logic signed [63:0] acc_next;
  logic               negative_next;
  logic               digit_seen_next;
  logic [1:0]         err_next;
  logic [1:0]         final_status;

  logic signed [63:0] scaled;
  logic [64:0]        sum;
  logic               too_big;
  logic               out_free;

  assign out_free = !result_valid || !result_stall;
  assign pop      = q_nonempty && (!q_head.last || out_free);

  assign scaled  = (acc <<< 3) + (acc <<< 1);
  assign too_big = (acc > dtoi_pkg::AccMaxDiv) || (acc < dtoi_pkg::AccMinDiv);
  assign sum     = negative ? {scaled[63], scaled} - {61'd0, q_head.digit}
                            : {scaled[63], scaled} + {61'd0, q_head.digit};

  always_comb begin
    acc_next        = acc;
    negative_next   = negative;
    digit_seen_next = digit_seen;
    err_next        = err;
    if (err == dtoi_pkg::StatusOk) begin
      case (q_head.kind)
        dtoi_pkg::KIND_MINUS: begin
          negative_next = 1'b1;
        end
        dtoi_pkg::KIND_BAD: begin
          err_next = dtoi_pkg::StatusInvalid;
        end
        dtoi_pkg::KIND_DIGIT: begin
          if (too_big || (sum[64] != sum[63])) begin
            err_next = dtoi_pkg::StatusRange;
          end else begin
            acc_next        = sum[63:0];
            digit_seen_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (err_next != dtoi_pkg::StatusOk) begin
      final_status = err_next;
    end else if (!digit_seen_next) begin
      final_status = dtoi_pkg::StatusInvalid;
    end else begin
      final_status = dtoi_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      negative   <= 1'b0;
      digit_seen <= 1'b0;
      err        <= dtoi_pkg::StatusOk;
    end else if (pop) begin
      if (q_head.last) begin
        acc        <= '0;
        negative   <= 1'b0;
        digit_seen <= 1'b0;
        err        <= dtoi_pkg::StatusOk;
      end else begin
        acc        <= acc_next;
        negative   <= negative_next;
        digit_seen <= digit_seen_next;
        err        <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && q_head.last) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_head.last) begin
      status <= final_status;
      value  <= (final_status == dtoi_pkg::StatusOk) ? acc_next : '0;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && q_head.last |=> acc == '0 && !negative && !digit_seen
                           && err == dtoi_pkg::StatusOk)
    else $error("state not cleared after end of string");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err != dtoi_pkg::StatusOk && !(pop && q_head.last) |=> err == $past(err))
    else $error("error code changed within a string");

  a_no_pop_over_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !(pop && q_head.last))
    else $error("result overwritten while stalled");

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != dtoi_pkg::StatusOk |-> value == '0)
    else $error("nonzero value with error status");
`endif

endmodule

`default_nettype wire

@@ rtl/decimal_text_to_int64_core.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_int64_core
// Parses a decimal number text, one byte per request, into a signed 64-bit
// value with invalid and out-of-range status.
// ----------------------------------------------------------------------------
// Takes one byte per cycle when neither side stalls; the result of a string
// is registered when its last item is popped from the queue. Bytes are
// classified on entry, pass through a four-entry queue, and each digit is
// folded into the accumulator (times ten by shift-add, one 65-bit add with
// overflow check). The result waits in an output register while following
// bytes keep flowing into the queue.
`default_nettype none

module decimal_text_to_int64_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         character,
  input  wire logic               no_character,
  input  wire logic               last_char,
  input  wire logic               char_valid,
  output logic                    char_stall,
  output logic signed [63:0]      value,
  output logic [1:0]              status,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  logic             push;
  dtoi_pkg::entry_t push_entry;
  logic             queue_full;
  logic             pop;
  logic             q_nonempty;
  dtoi_pkg::entry_t q_head;

  dtoi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .character    (character),
    .no_character (no_character),
    .last_char    (last_char),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  dtoi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  dtoi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .pop          (pop),
    .value        (value),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire
